// ===== src/sxd_pkg.sv =====
package sxd_pkg;

  localparam int KEY_LENGTH   = 214;
  localparam int TABLE_LENGTH = 214;
  localparam int HEADER_BYTES = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0]  BAD_BYTE_FILL = 8'h69;
  localparam logic [7:0]  KEY_TWO_RESET = 8'h33;
  localparam logic [7:0]  KEY_FOUR_RESET = 8'h08;
  localparam logic [7:0]  KEY_POS_TWO  = 8'd2;
  localparam logic [7:0]  KEY_POS_FOUR = 8'd4;
  localparam logic [8:0]  FULL_BLOCK   = 9'h100;
  localparam logic [16:0] ADDR_SPAN    = 17'h10000;
  localparam logic [7:0]  LAST_ID      = 8'd1;
  localparam logic [15:0] TALLY_MAX    = 16'hFFFF;

  localparam logic CFG_KEY_TWO  = 1'b0;
  localparam logic CFG_KEY_FOUR = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // one unit of work for the back end
  typedef struct packed {
    kind_t       kind;
    logic        clear;
    logic [15:0] address;
    logic [7:0]  key;
    logic [7:0]  raw;
    logic        read_error;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic        byte_bad;
    logic [7:0]  checksum_expected;
    logic [7:0]  checksum_read;
    logic        checksum_ok;
    logic [15:0] error_count;
    logic        last;
  } res_t;

  localparam logic [7:0] KEY_TABLE [0:TABLE_LENGTH-1] = '{
    8'h40,8'h3C,8'h33,8'h00,8'h08,8'hA2,8'h08,8'h20,8'h14,8'h00,8'h66,8'hFC,8'hCA,8'hD0,8'hF8,8'hA5,
    8'hFC,8'h60,8'hA9,8'h10,8'h2C,8'h0D,8'hDC,8'hF0,8'hFB,8'h4E,8'h0D,8'hDD,8'hA9,8'h19,8'h8D,8'h0E,
    8'hDD,8'hEE,8'h20,8'hD0,8'h60,8'h20,8'h14,8'h00,8'h66,8'hFC,8'hA5,8'hFC,8'hC9,8'hE3,8'hD0,8'hF5,
    8'h20,8'h07,8'h00,8'hC9,8'hE3,8'hF0,8'hF9,8'hC9,8'hED,8'hD0,8'hEA,8'h20,8'h07,8'h00,8'h85,8'hFA,
    8'h20,8'h07,8'h00,8'h85,8'hFD,8'h20,8'h07,8'h00,8'h85,8'hFE,8'h20,8'h07,8'h00,8'h85,8'hFB,8'hA0,
    8'h00,8'h20,8'h07,8'h00,8'hC6,8'h01,8'hA6,8'hF8,8'h55,8'h02,8'hE8,8'hE0,8'hD6,8'hD0,8'h02,8'hA2,
    8'h00,8'h86,8'hF8,8'h45,8'hFE,8'h45,8'hFD,8'h91,8'hFD,8'h45,8'hFF,8'h85,8'hFF,8'hE6,8'h01,8'hE6,
    8'hFD,8'hD0,8'h02,8'hE6,8'hFE,8'hC6,8'hFB,8'hD0,8'hD6,8'hC6,8'hFA,8'hD0,8'hBE,8'h20,8'h07,8'h00,
    8'hC5,8'hFF,8'hD0,8'h03,8'h4C,8'hCD,8'h00,8'hEE,8'h20,8'hD0,8'h4C,8'h89,8'h00,8'h78,8'hA9,8'h02,
    8'h8D,8'hFA,8'hFF,8'h8D,8'hFE,8'hFF,8'hA9,8'h00,8'h8D,8'hFB,8'hFF,8'h8D,8'hFF,8'hFF,8'hA9,8'h7F,
    8'h8D,8'h0D,8'hDC,8'h8D,8'h0D,8'hDD,8'hAD,8'h0D,8'hDC,8'hAD,8'h0D,8'hDD,8'hA9,8'h80,8'h8D,8'h04,
    8'hDD,8'hA9,8'h01,8'h8D,8'h05,8'hDD,8'h4A,8'h8D,8'h20,8'hD0,8'h8D,8'h20,8'hD0,8'h85,8'hFF,8'h85,
    8'hF9,8'h85,8'hF8,8'hA9,8'h19,8'h8D,8'h0E,8'hDD,8'h4C,8'h27,8'h00,8'hE6,8'hF9,8'hA6,8'hF9,8'hB5,
    8'h05,8'h48,8'hB5,8'h03,8'h48,8'h60
  };

  function automatic logic [7:0] key_at(input logic [7:0] pos, input logic [7:0] k2,
                                        input logic [7:0] k4);
    logic [7:0] k;
    k = 8'h00;
    if (pos == KEY_POS_TWO) begin
      k = k2;
    end else if (pos == KEY_POS_FOUR) begin
      k = k4;
    end else if (32'(pos) < TABLE_LENGTH) begin
      k = KEY_TABLE[pos];
    end
    return k;
  endfunction

endpackage

// ===== src/sxd_front.sv =====
module sxd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               accept,
  input  logic               first,
  input  logic [7:0]         raw,
  input  logic               read_error,
  output logic               push,
  output sxd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK,
    PH_DONE
  } phase_t;

  localparam logic [1:0] HDR_LAST = 2'(sxd_pkg::HEADER_BYTES - 1);
  localparam logic [7:0] KEY_LAST = 8'(sxd_pkg::KEY_LENGTH - 1);

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [1:0]  hidx_r, hidx_nxt, hidx_eff;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [8:0]  left_r, left_nxt, size;
  logic [7:0]  keypos_r, keypos_nxt, keypos_eff;
  logic        clear_pend_r, clear_pend_nxt;
  logic [7:0]  key_two_r, key_four_r;
  logic [16:0] span;

  always_comb begin
    phase_eff  = first ? PH_HEADER : phase_r;
    hidx_eff   = first ? 2'd0 : hidx_r;
    keypos_eff = first ? 8'd0 : keypos_r;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    id_nxt     = id_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    keypos_nxt = keypos_r;
    size       = (raw == 8'd0) ? sxd_pkg::FULL_BLOCK : {1'b0, raw};
    span       = {1'b0, addr_r} + {8'd0, size};
    push       = 1'b0;
    cmd.kind       = sxd_pkg::KIND_ERROR;
    cmd.clear      = first || clear_pend_r;
    cmd.address    = addr_r;
    cmd.key        = sxd_pkg::key_at(keypos_eff, key_two_r, key_four_r);
    cmd.raw        = raw;
    cmd.read_error = read_error;
    if (accept) begin
      keypos_nxt = keypos_eff;
      hidx_nxt   = hidx_eff;
      phase_nxt  = phase_eff;
      unique case (phase_eff)
        PH_HEADER: begin
          if (read_error) begin
            phase_nxt = PH_DONE;
            push      = 1'b1;
          end else begin
            unique case (hidx_eff)
              2'd0: id_nxt = raw;
              2'd1: addr_nxt = {addr_r[15:8], raw};
              2'd2: addr_nxt = {raw, addr_r[7:0]};
              default: ;
            endcase
            if (hidx_eff != HDR_LAST) begin
              hidx_nxt = hidx_eff + 2'd1;
            end else begin
              hidx_nxt = 2'd0;
              left_nxt = size;
              if (span > sxd_pkg::ADDR_SPAN || id_r == 8'd0) begin
                phase_nxt = PH_DONE;
                push      = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          push     = 1'b1;
          cmd.kind = sxd_pkg::KIND_DATA;
          if (!read_error) begin
            keypos_nxt = (keypos_eff >= KEY_LAST) ? 8'd0 : keypos_eff + 8'd1;
          end
          addr_nxt = addr_r + 16'd1;
          left_nxt = left_r - 9'd1;
          if (left_nxt == 9'd0) begin
            phase_nxt = (id_r == sxd_pkg::LAST_ID) ? PH_CHECK : PH_HEADER;
            hidx_nxt  = 2'd0;
          end
        end
        PH_CHECK: begin
          push      = 1'b1;
          cmd.kind  = sxd_pkg::KIND_CHECK;
          phase_nxt = PH_DONE;
        end
        PH_IDLE, PH_DONE: ;
        default: ;
      endcase
    end
    // carry the restart to whichever command goes out next
    clear_pend_nxt = push ? 1'b0 : ((accept && first) || clear_pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hidx_r       <= 2'd0;
      id_r         <= 8'd0;
      addr_r       <= 16'd0;
      left_r       <= 9'd0;
      keypos_r     <= 8'd0;
      clear_pend_r <= 1'b0;
      key_two_r    <= sxd_pkg::KEY_TWO_RESET;
      key_four_r   <= sxd_pkg::KEY_FOUR_RESET;
    end else begin
      phase_r      <= phase_nxt;
      hidx_r       <= hidx_nxt;
      id_r         <= id_nxt;
      addr_r       <= addr_nxt;
      left_r       <= left_nxt;
      keypos_r     <= keypos_nxt;
      clear_pend_r <= clear_pend_nxt;
      if (cfg_we && cfg_index == sxd_pkg::CFG_KEY_TWO) begin
        key_two_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == sxd_pkg::CFG_KEY_FOUR) begin
        key_four_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== src/sxd_queue.sv =====
module sxd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sxd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output sxd_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(sxd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sxd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(sxd_pkg::QUEUE_DEPTH);

  sxd_pkg::cmd_t    slot_r [0:sxd_pkg::QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == DEPTH);
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rd_r];

  always_comb begin
    wr_nxt  = (push && !full) ? PTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = (pop && nonempty) ? PTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push && !full) - CNT_W'(pop && nonempty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/sxd_back.sv =====
module sxd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sxd_pkg::cmd_t cmd,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_ready,
  output sxd_pkg::res_t res
);

  logic          valid_r;
  sxd_pkg::res_t res_r, res_nxt;
  logic [7:0]    cs_r, cs_nxt, cs_base, plain;
  logic [15:0]   tally_r, tally_nxt, tally_base, tally_inc;

  assign pop       = cmd_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    cs_base    = cmd.clear ? 8'd0 : cs_r;
    tally_base = cmd.clear ? 16'd0 : tally_r;
    tally_inc  = (tally_base == sxd_pkg::TALLY_MAX) ? tally_base : tally_base + 16'd1;
    plain      = cmd.raw ^ cmd.key ^ cmd.address[15:8] ^ cmd.address[7:0];
    cs_nxt     = cs_base;
    tally_nxt  = tally_base;
    res_nxt    = '0;
    res_nxt.kind = cmd.kind;
    unique case (cmd.kind)
      sxd_pkg::KIND_DATA: begin
        res_nxt.address  = cmd.address;
        res_nxt.byte_bad = cmd.read_error;
        if (cmd.read_error) begin
          res_nxt.value = sxd_pkg::BAD_BYTE_FILL;
          tally_nxt     = tally_inc;
        end else begin
          res_nxt.value = plain;
          cs_nxt        = cs_base ^ plain;
        end
      end
      sxd_pkg::KIND_CHECK: begin
        res_nxt.last = 1'b1;
        if (cmd.read_error) begin
          tally_nxt = tally_inc;
        end else begin
          res_nxt.checksum_read = cmd.raw;
          res_nxt.checksum_ok   = (cmd.raw == cs_base);
        end
      end
      sxd_pkg::KIND_ERROR: res_nxt.last = 1'b1;
      default: res_nxt.last = 1'b1;
    endcase
    res_nxt.checksum_expected = cs_nxt;
    res_nxt.error_count       = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cs_r    <= 8'd0;
      tally_r <= 16'd0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        cs_r    <= cs_nxt;
        tally_r <= tally_nxt;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/subblock_xor_decrypt_deframer_core.sv =====
// Deframes and decrypts the tape byte stream that follows the sync byte: header bytes
// (id, load address low/high, size) are parsed, each payload byte is XORed with the
// rolling key and both address bytes and is sent out with its address, and the file
// ends with a checksum result or a format error result (out_tlast marks both).
// Raise in_tuser on the first byte after sync to restart parsing. One beat is taken
// per clock cycle while the command queue is not full; a result passes through the
// four-entry command queue between the header parser and the decrypt stage, then the
// output register. Header bytes yield only error results, bytes outside a file none.
module subblock_xor_decrypt_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_value[7:0], read_error[8], zero[15:9]
  input  logic        in_tuser,   // first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // address[15:0], value[23:16], byte_bad[24],
                                  // checksum_expected[32:25], checksum_read[40:33],
                                  // checksum_ok[41], error_count[57:42], zero[63:58]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  logic          accept, push, full, pop, nonempty;
  sxd_pkg::cmd_t cmd, head;
  sxd_pkg::res_t res;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  sxd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .first      (in_tuser),
    .raw        (in_tdata[7:0]),
    .read_error (in_tdata[8]),
    .push       (push),
    .cmd        (cmd)
  );

  sxd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  sxd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (nonempty),
    .cmd       (head),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {6'd0, res.error_count, res.checksum_ok, res.checksum_read,
                      res.checksum_expected, res.byte_bad, res.value, res.address};

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != sxd_pkg::KIND_DATA)))
    else $error("tlast does not match result kind");

  a_data_no_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sxd_pkg::KIND_DATA |-> out_tdata[41:33] == 9'd0)
    else $error("data result carries checksum fields");

  a_check_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sxd_pkg::KIND_CHECK && out_tdata[41]
      |-> out_tdata[40:33] == out_tdata[32:25])
    else $error("checksum_ok set on mismatching checksum");

endmodule
